FILE: rtl/pid_position_or_delta_assert.svh
// Assertion macros for the checker file pid_chk.
`ifndef PID_POSITION_OR_DELTA_ASSERT_SVH
`define PID_POSITION_OR_DELTA_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pid_pkg.sv
package pid_pkg;

    localparam int FRAC_BITS = 16;

    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DE_W     = ERR_W + 1;
    localparam int DDE_W    = ERR_W + 2;
    localparam int GAIN_W   = 32;
    localparam int PROD_W   = GAIN_W + DDE_W;
    localparam int LIM_W    = 31;
    localparam int SLIM_W   = LIM_W + FRAC_BITS;
    // headroom for the three-term sums on top of the widest of limit or product
    localparam int SUM_W    = ((SLIM_W > PROD_W) ? SLIM_W : PROD_W) + 3;
    localparam int DRIVE_W  = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = CFG_IDX_W'(5);

    localparam logic CMD_CLEAR = 1'b1;
    localparam logic MODE_INC  = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // queue slots plus the integrator stage plus the output register
    localparam int INFLIGHT_MAX = QUEUE_DEPTH + 2;
    localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 2);

    typedef struct packed {
        logic                     loop_mode;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]         out_limit;
        logic [LIM_W-1:0]         integ_limit;
    } t_cfg;

    typedef struct packed {
        logic                     clr;
        logic signed [PROD_W-1:0] pp;
        logic signed [PROD_W-1:0] pi;
        logic signed [PROD_W-1:0] pd;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/pid_if.sv
interface pid_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [pid_pkg::SAMPLE_W-1:0] setpoint;
    logic signed [pid_pkg::SAMPLE_W-1:0] feedback;

    modport source (output valid, cmd, setpoint, feedback, input ready);
    modport sink   (input valid, cmd, setpoint, feedback, output ready);
endinterface

interface pid_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pid_pkg::DRIVE_W-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

FILE: rtl/pid_queue.sv
module pid_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pid_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output pid_pkg::t_entry   o_entry,
    output pid_pkg::t_q_stat  o_stat
);

    pid_pkg::t_entry                   r_mem [pid_pkg::QUEUE_DEPTH];
    logic [pid_pkg::Q_PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [pid_pkg::Q_PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [pid_pkg::Q_CNT_W-1:0]       r_cnt, n_cnt;

    localparam logic [pid_pkg::Q_PTR_W-1:0] PTR_LAST = pid_pkg::Q_PTR_W'(pid_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == pid_pkg::Q_CNT_W'(pid_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

FILE: rtl/pid_front.sv
module pid_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pid_in_if.sink            i_in,
    input  pid_pkg::t_cfg     i_cfg,
    input  pid_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output pid_pkg::t_entry   o_entry
);

    logic signed [pid_pkg::ERR_W-1:0] r_e1, n_e1;
    logic signed [pid_pkg::ERR_W-1:0] r_e2, n_e2;
    logic signed [pid_pkg::ERR_W-1:0] w_e;
    logic signed [pid_pkg::DE_W-1:0]  w_de;
    logic signed [pid_pkg::DDE_W-1:0] w_dde;
    logic signed [pid_pkg::DDE_W-1:0] w_op_p, w_op_i, w_op_d;

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        w_e   = {i_in.setpoint[pid_pkg::SAMPLE_W-1], i_in.setpoint}
              - {i_in.feedback[pid_pkg::SAMPLE_W-1], i_in.feedback};
        w_de  = {w_e[pid_pkg::ERR_W-1], w_e} - {r_e1[pid_pkg::ERR_W-1], r_e1};
        // e - 2*e1 + e2
        w_dde = {{2{w_e[pid_pkg::ERR_W-1]}}, w_e}
              - {r_e1[pid_pkg::ERR_W-1], r_e1, 1'b0}
              + {{2{r_e2[pid_pkg::ERR_W-1]}}, r_e2};

        w_op_i = {{2{w_e[pid_pkg::ERR_W-1]}}, w_e};
        if (i_cfg.loop_mode == pid_pkg::MODE_INC) begin
            w_op_p = {w_de[pid_pkg::DE_W-1], w_de};
            w_op_d = w_dde;
        end else begin
            w_op_p = w_op_i;
            w_op_d = {w_de[pid_pkg::DE_W-1], w_de};
        end

        o_entry.clr = (i_in.cmd == pid_pkg::CMD_CLEAR);
        o_entry.pp  = pid_pkg::PROD_W'(i_cfg.kp) * pid_pkg::PROD_W'(w_op_p);
        o_entry.pi  = pid_pkg::PROD_W'(i_cfg.ki) * pid_pkg::PROD_W'(w_op_i);
        o_entry.pd  = pid_pkg::PROD_W'(i_cfg.kd) * pid_pkg::PROD_W'(w_op_d);

        n_e1 = r_e1;
        n_e2 = r_e2;
        if (o_push) begin
            if (i_in.cmd == pid_pkg::CMD_CLEAR) begin
                n_e1 = '0;
                n_e2 = '0;
            end else begin
                n_e1 = w_e;
                n_e2 = r_e1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= '0;
            r_e2 <= '0;
        end else begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end
    end

endmodule

FILE: rtl/pid_back.sv
module pid_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pid_pkg::t_cfg     i_cfg,
    input  pid_pkg::t_q_stat  i_q_stat,
    input  pid_pkg::t_entry   i_entry,
    output logic              o_pop,
    pid_out_if.source         o_res
);

    localparam int SW = pid_pkg::SUM_W;
    localparam int PW = pid_pkg::PROD_W;

    function automatic logic signed [SW-1:0] clamp_sym(
        input logic signed [SW-1:0] x,
        input logic signed [SW-1:0] lim
    );
        logic signed [SW-1:0] res;
        res = x;
        if (x > lim) begin
            res = lim;
        end else if (x < -lim) begin
            res = -lim;
        end
        return res;
    endfunction

    logic                 w_adv;
    logic                 w_inc;
    logic signed [SW-1:0] w_ilim, w_olim;
    logic signed [SW-1:0] w_pp, w_pi, w_pd;
    logic signed [SW-1:0] w_base;
    logic signed [SW-1:0] n_integ, n_b1_sum, n_out_acc;

    logic                 r_b1_v;
    logic                 r_b1_clr;
    logic signed [SW-1:0] r_b1_sum;
    logic signed [SW-1:0] r_integ;
    logic                 r_ovalid;
    logic signed [SW-1:0] r_out_acc;

    assign w_adv = !r_ovalid || o_res.ready;
    assign o_pop = w_adv && !i_q_stat.empty;
    assign w_inc = (i_cfg.loop_mode == pid_pkg::MODE_INC);

    always_comb begin
        w_ilim = {{(SW-pid_pkg::SLIM_W){1'b0}}, i_cfg.integ_limit, {pid_pkg::FRAC_BITS{1'b0}}};
        w_olim = {{(SW-pid_pkg::SLIM_W){1'b0}}, i_cfg.out_limit, {pid_pkg::FRAC_BITS{1'b0}}};
        w_pp   = {{(SW-PW){i_entry.pp[PW-1]}}, i_entry.pp};
        w_pi   = {{(SW-PW){i_entry.pi[PW-1]}}, i_entry.pi};
        w_pd   = {{(SW-PW){i_entry.pd[PW-1]}}, i_entry.pd};

        // integrator stage
        if (i_entry.clr) begin
            n_integ = '0;
        end else if (w_inc) begin
            n_integ = w_pi;
        end else begin
            n_integ = clamp_sym(r_integ + w_pi, w_ilim);
        end
        n_b1_sum = w_pp + w_pd + (w_inc ? w_pi : '0);

        // output stage: delta mode accumulates onto the kept output
        w_base = w_inc ? r_out_acc : r_integ;
        if (r_b1_clr) begin
            n_out_acc = '0;
        end else begin
            n_out_acc = clamp_sym(w_base + r_b1_sum, w_olim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v    <= 1'b0;
            r_integ   <= '0;
            r_ovalid  <= 1'b0;
            r_out_acc <= '0;
        end else if (w_adv) begin
            r_b1_v   <= !i_q_stat.empty;
            r_ovalid <= r_b1_v;
            if (!i_q_stat.empty) begin
                r_integ <= n_integ;
            end
            if (r_b1_v) begin
                r_out_acc <= n_out_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_clr <= i_entry.clr;
            r_b1_sum <= n_b1_sum;
        end
    end

    assign o_res.valid = r_ovalid;
    // arithmetic floor of the kept output is just its integer bits
    assign o_res.drive = r_out_acc[pid_pkg::FRAC_BITS +: pid_pkg::DRIVE_W];

endmodule

FILE: rtl/pid_position_or_delta.sv
// PID controller, positional or incremental (delta), signed Q16.16 gains.
// One transaction on i_in carries a command bit, a setpoint and a feedback
// sample; every transaction, a clear included, yields exactly one transaction
// on o_res carrying the clamped drive (integer part, floor). The block takes
// one transaction per clock, sustained while o_res is not stalled; a result
// passes the queue slot, then the integrator stage, then the output register
// before it is presented on o_res, and is taken there once o_res is not
// stalled. The rate is set by the integrator and output accumulators in
// the back stage, each of which closes its feedback loop through one register.
// Registers are written through the plain write port and should be changed
// only while no transaction is in flight.
module pid_position_or_delta (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pid_in_if.sink                           i_in,
    pid_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [pid_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pid_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pid_pkg::t_cfg     r_cfg;
    pid_pkg::t_entry   w_push_entry;
    pid_pkg::t_entry   w_pop_entry;
    pid_pkg::t_q_stat  w_q_stat;
    logic              w_push;
    logic              w_pop;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pid_pkg::CFG_LOOP_MODE:   r_cfg.loop_mode   <= i_cfg_data[0];
                pid_pkg::CFG_KP_GAIN:     r_cfg.kp          <= i_cfg_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::CFG_KI_GAIN:     r_cfg.ki          <= i_cfg_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::CFG_KD_GAIN:     r_cfg.kd          <= i_cfg_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::CFG_OUT_LIMIT:   r_cfg.out_limit   <= i_cfg_data[pid_pkg::LIM_W-1:0];
                pid_pkg::CFG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[pid_pkg::LIM_W-1:0];
                default:                  r_cfg             <= r_cfg;
            endcase
        end
    end

    // Front: forms the error and its differences from the error history,
    // decodes the clear command and runs the three gain multiplies.
    pid_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // Queue: holds the registered products, so the front keeps taking
    // transactions until it fills while the back waits on a stalled output.
    pid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    // Back: integrator update (clamped in positional mode), then output sum and
    // clamp into the output register, which doubles as the kept output of delta mode.
    pid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .i_entry  (w_pop_entry),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

endmodule

FILE: rtl/pid_chk.sv
`include "pid_position_or_delta_assert.svh"

module pid_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_res_valid,
    input logic                                  i_res_ready,
    input logic signed [pid_pkg::DRIVE_W-1:0]    i_res_drive,
    input logic                                  i_cfg_we,
    input logic [pid_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input logic [pid_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [pid_pkg::LIM_W-1:0]      r_lim;
    logic [pid_pkg::INFLIGHT_W-1:0] r_cnt;
    logic                           w_in_acc, w_out_acc;
    logic signed [pid_pkg::DRIVE_W-1:0] w_lim;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_res_valid && i_res_ready;
    assign w_lim     = {1'b0, r_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == pid_pkg::CFG_OUT_LIMIT)) begin
                r_lim <= i_cfg_data[pid_pkg::LIM_W-1:0];
            end
            case ({w_in_acc, w_out_acc})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `PID_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_drive), "stalled result changed")
    `PID_ASSERT_NOW(a_drive_range, i_clk, i_rst_n, i_res_valid, (i_res_drive <= w_lim) && (i_res_drive >= -w_lim), "drive outside output limit")
    `PID_ASSERT_NOW(a_inflight_max, i_clk, i_rst_n, 1'b1, r_cnt <= pid_pkg::INFLIGHT_W'(pid_pkg::INFLIGHT_MAX), "too many transactions in flight")
    `PID_ASSERT_NOW(a_no_orphan, i_clk, i_rst_n, i_res_valid, r_cnt != '0, "result without a pending input")

endmodule

bind pid_position_or_delta pid_chk u_pid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_drive (o_res.drive),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data)
);

FILE: bench/pid_drive_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts each drive value and
// compares it with what the block returns, oldest first.
module pid_drive_checker
    import pid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pid_in_if                     i_in,
    pid_out_if                    i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;

    // register copy
    logic   loop_inc;
    longint kp, ki, kd;
    longint out_lim, integ_lim;

    // controller state, FRAC_BITS fraction bits in the accumulators
    longint err_last, err_older;
    longint integ_q, out_q;

    logic signed [DRIVE_W-1:0] drive_due[$];

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // Advances the controller copy by one transaction, returns the drive.
    function automatic logic signed [DRIVE_W-1:0] step_drive(
        input logic                       cmd,
        input logic signed [SAMPLE_W-1:0] sp,
        input logic signed [SAMPLE_W-1:0] fb
    );
        longint e, e1, e2, olim_fx;
        if (cmd == CMD_CLEAR) begin
            err_last  = 0;
            err_older = 0;
            integ_q   = 0;
            out_q     = 0;
            return '0;
        end
        e       = longint'(sp) - longint'(fb);
        e1      = err_last;
        e2      = err_older;
        olim_fx = out_lim <<< FRAC_BITS;
        if (loop_inc != MODE_INC) begin
            integ_q = clamp_sym(integ_q + ki * e, integ_lim <<< FRAC_BITS);
            out_q   = clamp_sym(kp * e + integ_q + kd * (e - e1), olim_fx);
        end else begin
            // incremental: integrator holds only this step's term, unclamped
            integ_q = ki * e;
            out_q   = clamp_sym(out_q + kp * (e - e1) + integ_q
                                + kd * (e - 2 * e1 + e2), olim_fx);
        end
        err_older = e1;
        err_last  = e;
        return DRIVE_W'(out_q >>> FRAC_BITS);   // arithmetic shift = floor
    endfunction

    always @(posedge i_clk) begin : mon
        logic signed [DRIVE_W-1:0] due;
        if (!i_rst_n) begin
            loop_inc  = 1'b0;
            kp        = 0;
            ki        = 0;
            kd        = 0;
            out_lim   = 0;
            integ_lim = 0;
            err_last  = 0;
            err_older = 0;
            integ_q   = 0;
            out_q     = 0;
            drive_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOOP_MODE:   loop_inc  = i_cfg_data[0];
                    CFG_KP_GAIN:     kp        = longint'($signed(i_cfg_data));
                    CFG_KI_GAIN:     ki        = longint'($signed(i_cfg_data));
                    CFG_KD_GAIN:     kd        = longint'($signed(i_cfg_data));
                    CFG_OUT_LIMIT:   out_lim   = longint'(i_cfg_data[LIM_W-1:0]);
                    CFG_INTEG_LIMIT: integ_lim = longint'(i_cfg_data[LIM_W-1:0]);
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (drive_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("unexpected drive %0d with nothing pending", i_res.drive);
                end else begin
                    due = drive_due.pop_front();
                    if (i_res.drive !== due) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS)
                            $display("drive mismatch: expected %0d, got %0d",
                                     due, i_res.drive);
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                drive_due.push_back(step_drive(i_in.cmd, i_in.setpoint, i_in.feedback));
        end
        o_pending = drive_due.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pid_pkg::*;

    localparam int     CLK_HALF_NS     = 5;
    localparam int     RESET_CYCLES    = 9;
    // margin after the last pending result has been taken
    localparam int     DRAIN_CYCLES    = 8;
    localparam longint TIMEOUT_NS      = 5_000_000;
    localparam int     PHASES          = 16;
    localparam int     ITEMS_PER_PHASE = 90;
    localparam int     HEAVY_IDLE_PCT  = 85;
    localparam int     BOTH_IDLE_PCT   = 12;
    // moderate gains span +-4.0
    localparam int     GAIN_SPAN       = 1 << (FRAC_BITS + 2);

    localparam logic CMD_STEP = ~CMD_CLEAR;
    localparam logic MODE_POS = ~MODE_INC;

    // register indexes past the last real register; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_INTEG_LIMIT + 1'b1;
    localparam int SPARE_SPAN = (1 << CFG_IDX_W) - int'(CFG_FIRST_SPARE);

    typedef enum logic [1:0] {GAP_NONE, GAP_SRC, GAP_SNK, GAP_BOTH} t_gap_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    t_gap_mode             gap_mode;
    int                    target;
    int                    roll;

    pid_in_if  in_ch ();
    pid_out_if res_ch ();

    pid_position_or_delta dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pid_drive_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // Result side back-pressure. Changes on the falling edge only, so the
    // checker sees a settled value at the rising edge.
    always @(negedge clk) begin
        case (gap_mode)
            GAP_SNK:  res_ch.ready <= $urandom_range(99) >= HEAVY_IDLE_PCT;
            GAP_BOTH: res_ch.ready <= $urandom_range(99) >= BOTH_IDLE_PCT;
            default:  res_ch.ready <= 1'b1;
        endcase
    end

    // Hard stop in case the block hangs somewhere.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sender idle decision for the current cycle.
    function automatic bit src_idles();
        case (gap_mode)
            GAP_SRC:  return $urandom_range(99) < HEAVY_IDLE_PCT;
            GAP_BOTH: return $urandom_range(99) < BOTH_IDLE_PCT;
            default:  return 1'b0;
        endcase
    endfunction

    // Gains: extremes, zero, full-range noise, or something a real loop uses.
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return 32'(int'($urandom_range(2 * GAIN_SPAN)) - GAIN_SPAN);
        endcase
    endfunction

    // Limits are 31 bits wide; full 32-bit noise also checks that bit 31 is dropped.
    function automatic logic [31:0] pick_limit();
        case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(20000);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_edge();
        case ($urandom_range(3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sat16(input int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return 16'(v);
    endfunction

    // One input transaction. Entered and left right after a falling edge;
    // valid stays high between back-to-back transactions.
    task automatic send_txn(input logic cmd, input logic [SAMPLE_W-1:0] sp,
                            input logic [SAMPLE_W-1:0] fb);
        while (src_idles()) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= cmd;
        in_ch.setpoint <= sp;
        in_ch.feedback <= fb;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding transaction come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write enable is left high across a burst and lowered by the caller,
    // so it never gets two assignments in one step.
    task automatic cfg_wr(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // Full register load, only once the pipe is empty. A write to an unused
    // index goes last so a stray decode would not be hidden by a later write.
    task automatic apply_cfg(input logic mode, input logic [31:0] kp, ki, kd, olim, ilim);
        drain();
        cfg_wr(CFG_LOOP_MODE, {31'($urandom), mode});
        cfg_wr(CFG_KP_GAIN, kp);
        cfg_wr(CFG_KI_GAIN, ki);
        cfg_wr(CFG_KD_GAIN, kd);
        cfg_wr(CFG_OUT_LIMIT, olim);
        cfg_wr(CFG_INTEG_LIMIT, ilim);
        cfg_wr(CFG_FIRST_SPARE + CFG_IDX_W'($urandom_range(SPARE_SPAN - 1)), $urandom);
        cfg_we <= 1'b0;
    endtask

    initial begin
        // every block input known from time zero
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_STEP;
        in_ch.setpoint = '0;
        in_ch.feedback = '0;
        res_ch.ready   = 1'b0;
        gap_mode       = GAP_NONE;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part, no idling ----
        // positional, unit kp, quarter ki, negative half kd, modest clamps
        apply_cfg(MODE_POS, 32'h0001_0000, 32'h0000_4000, 32'hFFFF_8000, 32'd1000, 32'd300);
        send_txn(CMD_CLEAR, 16'h1234, 16'hFEDC);   // clear ignores the samples
        send_txn(CMD_STEP, 16'h7FFF, 16'h8000);    // largest positive error
        send_txn(CMD_STEP, 16'h8000, 16'h7FFF);    // largest negative error
        send_txn(CMD_STEP, 16'h0000, 16'h0000);
        send_txn(CMD_STEP, 16'd100, 16'd0);
        send_txn(CMD_STEP, 16'd100, 16'd50);
        send_txn(CMD_STEP, 16'hFFFB, 16'd7);       // small negative error, floor

        // switch to incremental without a clear: carries on from kept state
        apply_cfg(MODE_INC, 32'h0001_0000, 32'h0000_4000, 32'hFFFF_8000, 32'd1000, 32'd300);
        send_txn(CMD_STEP, 16'd1, 16'd0);
        send_txn(CMD_STEP, 16'h8000, 16'h7FFF);
        send_txn(CMD_STEP, 16'h7FFF, 16'h8000);
        send_txn(CMD_STEP, 16'h0000, 16'h0000);
        send_txn(CMD_CLEAR, 16'h8000, 16'h7FFF);

        // extreme gains with widest clamps (bit 31 of the limit must be dropped)
        apply_cfg(MODE_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_txn(CMD_STEP, 16'h7FFF, 16'h8000);
        send_txn(CMD_STEP, 16'h8000, 16'h7FFF);
        send_txn(CMD_STEP, 16'h0000, 16'h0000);

        // zero clamps force the output to zero
        apply_cfg(MODE_INC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
        send_txn(CMD_STEP, 16'd1000, 16'hFC18);
        send_txn(CMD_STEP, 16'hFFFB, 16'd3);

        // zero integrator clamp, wide output clamp: integrator held at zero
        apply_cfg(MODE_POS, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'd0);
        send_txn(CMD_STEP, 16'd200, 16'd0);
        send_txn(CMD_STEP, 16'hFF38, 16'd0);

        // ---- random part ----
        // Each phase loads new registers (mode switches usually without a
        // clear) and takes the next idling pattern in turn. Most samples track
        // a setpoint like a closed loop would; the rest is noise and edges.
        for (int ph = 0; ph < PHASES; ph++) begin
            apply_cfg(1'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain(),
                      pick_limit(), pick_limit());
            gap_mode <= t_gap_mode'(ph % 4);
            target = int'($urandom_range(65535)) - 32768;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    send_txn(CMD_CLEAR, 16'($urandom), 16'($urandom));
                end else if (roll < 16) begin
                    send_txn(CMD_STEP, 16'($urandom), 16'($urandom));
                end else if (roll < 22) begin
                    send_txn(CMD_STEP, pick_edge(), pick_edge());
                end else begin
                    // occasional setpoint step, feedback close to it
                    if ($urandom_range(19) == 0)
                        target = int'($urandom_range(65535)) - 32768;
                    send_txn(CMD_STEP, 16'(target),
                             sat16(target + int'($urandom_range(400)) - 200));
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pid_pkg.sv
rtl/pid_if.sv
rtl/pid_queue.sv
rtl/pid_front.sv
rtl/pid_back.sv
rtl/pid_position_or_delta.sv
rtl/pid_chk.sv
bench/pid_drive_checker.sv
bench/tb_top.sv
